// ----- src/lcdwf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD window sender package
// Shared constants, codes, payload types and the window header table.
// ----------------------------------------------------------------------------
package lcdwf_pkg;

   // Frame store geometry and upscale factor.
   localparam int STORE_COLS  = 60;
   localparam int STORE_ROWS  = 80;
   localparam int SCALE       = 2;
   localparam int STORE_DEPTH = STORE_COLS * STORE_ROWS;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int COL_W       = (STORE_COLS > 1) ? $clog2(STORE_COLS) : 1;
   localparam int ROW_W       = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;
   localparam int SUB_W       = (SCALE > 1) ? $clog2(SCALE) : 1;

   localparam logic [8:0] WIN_X_LAST = 9'(STORE_COLS * SCALE - 1);
   localparam logic [8:0] WIN_Y_LAST = 9'(STORE_ROWS * SCALE - 1);

   // Panel command bytes.
   localparam logic [7:0] PNL_COL_ADDR  = 8'h2A;
   localparam logic [7:0] PNL_ROW_ADDR  = 8'h2B;
   localparam logic [7:0] PNL_MEM_WRITE = 8'h2C;

   // Window header byte positions.
   localparam logic [3:0] HS_COL_CMD   = 4'd0;
   localparam logic [3:0] HS_XS_HI     = 4'd1;
   localparam logic [3:0] HS_XS_LO     = 4'd2;
   localparam logic [3:0] HS_XE_HI     = 4'd3;
   localparam logic [3:0] HS_XE_LO     = 4'd4;
   localparam logic [3:0] HS_ROW_CMD   = 4'd5;
   localparam logic [3:0] HS_YS_HI     = 4'd6;
   localparam logic [3:0] HS_YS_LO     = 4'd7;
   localparam logic [3:0] HS_YE_HI     = 4'd8;
   localparam logic [3:0] HS_YE_LO     = 4'd9;
   localparam logic [3:0] HEADER_LEN   = 4'd11;

   typedef enum logic [1:0] {
      CMD_FILL  = 2'd0,
      CMD_RECT  = 2'd1,
      CMD_FRAME = 2'd2,
      CMD_TICK  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_RECT  = 2'd1,
      MODE_FRAME = 2'd2
   } mode_type;

   typedef enum logic {
      CTL_IDLE = 1'b0,
      CTL_READ = 1'b1
   } ctl_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_data;
      logic       last;
   } beat_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [15:0]       data;
   } store_wr_type;

   typedef struct packed {
      logic start_rect;
      logic start_frame;
      logic advance;
   } snd_ctrl_type;

   typedef struct packed {
      logic              busy;
      logic              need_read;
      logic [ADDR_W-1:0] rd_addr;
   } snd_status_type;

   // One byte of the window header; the corner values are 9 bits wide.
   function automatic beat_type header_beat(input logic [3:0] step,
                                            input logic [8:0] xs,
                                            input logic [8:0] xe,
                                            input logic [8:0] ys,
                                            input logic [8:0] ye);
      beat_type b;
      b.is_data = 1'b1;
      b.last    = 1'b0;
      case (step)
         HS_COL_CMD: begin
            b.out_byte = PNL_COL_ADDR;
            b.is_data  = 1'b0;
         end
         HS_XS_HI: b.out_byte = {7'd0, xs[8]};
         HS_XS_LO: b.out_byte = xs[7:0];
         HS_XE_HI: b.out_byte = {7'd0, xe[8]};
         HS_XE_LO: b.out_byte = xe[7:0];
         HS_ROW_CMD: begin
            b.out_byte = PNL_ROW_ADDR;
            b.is_data  = 1'b0;
         end
         HS_YS_HI: b.out_byte = {7'd0, ys[8]};
         HS_YS_LO: b.out_byte = ys[7:0];
         HS_YE_HI: b.out_byte = {7'd0, ye[8]};
         HS_YE_LO: b.out_byte = ye[7:0];
         default: begin
            b.out_byte = PNL_MEM_WRITE;
            b.is_data  = 1'b0;
         end
      endcase
      return b;
   endfunction

endpackage

// ----- src/lcdwf_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD window sender channels
// Valid/ready channels for command transactions and panel byte transactions.
// ----------------------------------------------------------------------------
interface lcdwf_req_if import lcdwf_pkg::*; ();
   logic        valid;
   logic        ready;
   cmd_type     cmd;
   logic [7:0]  x;
   logic [7:0]  y;
   logic [7:0]  width;
   logic [7:0]  height;
   logic [15:0] color;

   modport source (output valid, cmd, x, y, width, height, color, input ready);
   modport sink   (input valid, cmd, x, y, width, height, color, output ready);
endinterface

interface lcdwf_rsp_if import lcdwf_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       is_data;
   logic       last;

   modport source (output valid, out_byte, is_data, last, input ready);
   modport sink   (input valid, out_byte, is_data, last, output ready);
endinterface

// ----- src/lcdwf_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD window sender frame store
// RGB565 pixel memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lcdwf_store import lcdwf_pkg::*; (
   input  logic              clock,
   input  store_wr_type      wr,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [15:0]       rd_data
);

   logic [15:0] mem [STORE_DEPTH];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/lcdwf_fill.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD window sender store fill walker
// Walks a clipped rectangle of the frame store, one pixel write per cycle.
// ----------------------------------------------------------------------------
module lcdwf_fill import lcdwf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [7:0]   x,
   input  logic [7:0]   y,
   input  logic [7:0]   width,
   input  logic [7:0]   height,
   input  logic [15:0]  color,
   output logic         busy,
   output store_wr_type wr
);

   logic             active_ff, active_in;
   logic [COL_W-1:0] col_ff, col_in, col_first_ff, col_first_in, col_last_ff, col_last_in;
   logic [ROW_W-1:0] row_ff, row_in, row_last_ff, row_last_in;
   logic [15:0]      color_ff, color_in;
   logic [8:0]       x_end, y_end;
   logic             empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
      col_ff       <= col_in;
      col_first_ff <= col_first_in;
      col_last_ff  <= col_last_in;
      row_ff       <= row_in;
      row_last_ff  <= row_last_in;
      color_ff     <= color_in;
   end

   always_comb begin
      x_end = {1'b0, x} + {1'b0, width};
      y_end = {1'b0, y} + {1'b0, height};
      // A rectangle that starts outside the store leaves nothing after clipping.
      empty = (width == 8'd0) || (height == 8'd0) ||
              ({1'b0, x} >= 9'(STORE_COLS)) || ({1'b0, y} >= 9'(STORE_ROWS));

      active_in    = active_ff;
      col_in       = col_ff;
      col_first_in = col_first_ff;
      col_last_in  = col_last_ff;
      row_in       = row_ff;
      row_last_in  = row_last_ff;
      color_in     = color_ff;

      if (active_ff) begin
         if (col_ff == col_last_ff) begin
            col_in = col_first_ff;
            if (row_ff == row_last_ff) begin
               active_in = 1'b0;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end else if (start && !empty) begin
         active_in    = 1'b1;
         col_in       = COL_W'(x);
         col_first_in = COL_W'(x);
         row_in       = ROW_W'(y);
         color_in     = color;
         col_last_in  = (x_end > 9'(STORE_COLS)) ? COL_W'(STORE_COLS - 1)
                                                  : COL_W'(x_end - 9'd1);
         row_last_in  = (y_end > 9'(STORE_ROWS)) ? ROW_W'(STORE_ROWS - 1)
                                                  : ROW_W'(y_end - 9'd1);
      end
   end

   assign busy    = active_ff;
   assign wr.en   = active_ff;
   assign wr.addr = ADDR_W'(row_ff) * ADDR_W'(STORE_COLS) + ADDR_W'(col_ff);
   assign wr.data = color_ff;

endmodule

// ----- src/lcdwf_sender.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD window sender panel sequencer
// Holds the window, the rectangle fill and the frame scan position, and forms
// the next panel byte.
// ----------------------------------------------------------------------------
module lcdwf_sender import lcdwf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  snd_ctrl_type   ctrl,
   input  logic [7:0]     x,
   input  logic [7:0]     y,
   input  logic [7:0]     width,
   input  logic [7:0]     height,
   input  logic [15:0]    color,
   input  logic [15:0]    pix_data,
   output snd_status_type status,
   output beat_type       beat
);

   mode_type         mode_ff, mode_in;
   logic [3:0]       header_step_ff, header_step_in;
   logic [8:0]       win_xs_ff, win_xs_in, win_xe_ff, win_xe_in;
   logic [8:0]       win_ys_ff, win_ys_in, win_ye_ff, win_ye_in;
   logic [15:0]      fill_color_ff, fill_color_in;
   logic [15:0]      pixels_left_ff, pixels_left_in;
   logic             second_byte_ff, second_byte_in;
   logic [COL_W-1:0] src_col_ff, src_col_in;
   logic [ROW_W-1:0] src_row_ff, src_row_in;
   logic [SUB_W-1:0] sub_col_ff, sub_col_in, sub_row_ff, sub_row_in;
   logic             in_header, col_wrap, row_wrap, frame_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_IDLE;
         header_step_ff <= 4'd0;
         second_byte_ff <= 1'b0;
         win_xs_ff      <= 9'd0;
         win_xe_ff      <= 9'd0;
         win_ys_ff      <= 9'd0;
         win_ye_ff      <= 9'd0;
         pixels_left_ff <= 16'd0;
         src_col_ff     <= '0;
         src_row_ff     <= '0;
         sub_col_ff     <= '0;
         sub_row_ff     <= '0;
      end else begin
         mode_ff        <= mode_in;
         header_step_ff <= header_step_in;
         second_byte_ff <= second_byte_in;
         win_xs_ff      <= win_xs_in;
         win_xe_ff      <= win_xe_in;
         win_ys_ff      <= win_ys_in;
         win_ye_ff      <= win_ye_in;
         pixels_left_ff <= pixels_left_in;
         src_col_ff     <= src_col_in;
         src_row_ff     <= src_row_in;
         sub_col_ff     <= sub_col_in;
         sub_row_ff     <= sub_row_in;
      end
      fill_color_ff <= fill_color_in;
   end

   assign in_header  = header_step_ff < HEADER_LEN;
   assign col_wrap   = (sub_col_ff == SUB_W'(SCALE - 1)) &&
                       (src_col_ff == COL_W'(STORE_COLS - 1));
   assign row_wrap   = (sub_row_ff == SUB_W'(SCALE - 1)) &&
                       (src_row_ff == ROW_W'(STORE_ROWS - 1));
   assign frame_done = second_byte_ff && col_wrap && row_wrap;

   always_comb begin
      mode_in        = mode_ff;
      header_step_in = header_step_ff;
      second_byte_in = second_byte_ff;
      win_xs_in      = win_xs_ff;
      win_xe_in      = win_xe_ff;
      win_ys_in      = win_ys_ff;
      win_ye_in      = win_ye_ff;
      fill_color_in  = fill_color_ff;
      pixels_left_in = pixels_left_ff;
      src_col_in     = src_col_ff;
      src_row_in     = src_row_ff;
      sub_col_in     = sub_col_ff;
      sub_row_in     = sub_row_ff;

      if (ctrl.start_rect && mode_ff == MODE_IDLE &&
          width != 8'd0 && height != 8'd0) begin
         mode_in        = MODE_RECT;
         header_step_in = 4'd0;
         second_byte_in = 1'b0;
         win_xs_in      = {1'b0, x};
         win_ys_in      = {1'b0, y};
         win_xe_in      = {1'b0, x} + {1'b0, width} - 9'd1;
         win_ye_in      = {1'b0, y} + {1'b0, height} - 9'd1;
         fill_color_in  = color;
         pixels_left_in = 16'(width) * 16'(height);
      end else if (ctrl.start_frame && mode_ff == MODE_IDLE) begin
         mode_in        = MODE_FRAME;
         header_step_in = 4'd0;
         second_byte_in = 1'b0;
         win_xs_in      = 9'd0;
         win_ys_in      = 9'd0;
         win_xe_in      = WIN_X_LAST;
         win_ye_in      = WIN_Y_LAST;
         src_col_in     = '0;
         src_row_in     = '0;
         sub_col_in     = '0;
         sub_row_in     = '0;
      end else if (ctrl.advance) begin
         if (in_header) begin
            header_step_in = header_step_ff + 4'd1;
         end else begin
            second_byte_in = !second_byte_ff;
            case (mode_ff)
               MODE_RECT: begin
                  if (second_byte_ff) begin
                     pixels_left_in = pixels_left_ff - 16'd1;
                     if (pixels_left_ff == 16'd1) begin
                        mode_in        = MODE_IDLE;
                        header_step_in = 4'd0;
                     end
                  end
               end
               MODE_FRAME: begin
                  // Each store pixel covers SCALE panel columns and SCALE rows.
                  if (second_byte_ff) begin
                     if (sub_col_ff == SUB_W'(SCALE - 1)) begin
                        sub_col_in = '0;
                        if (src_col_ff == COL_W'(STORE_COLS - 1)) begin
                           src_col_in = '0;
                           if (sub_row_ff == SUB_W'(SCALE - 1)) begin
                              sub_row_in = '0;
                              if (src_row_ff == ROW_W'(STORE_ROWS - 1)) begin
                                 src_row_in = '0;
                              end else begin
                                 src_row_in = src_row_ff + 1'b1;
                              end
                           end else begin
                              sub_row_in = sub_row_ff + 1'b1;
                           end
                        end else begin
                           src_col_in = src_col_ff + 1'b1;
                        end
                     end else begin
                        sub_col_in = sub_col_ff + 1'b1;
                     end
                     if (frame_done) begin
                        mode_in        = MODE_IDLE;
                        header_step_in = 4'd0;
                     end
                  end
               end
               default: begin
                  second_byte_in = second_byte_ff;
               end
            endcase
         end
      end
   end

   always_comb begin
      beat = '0;
      if (in_header) begin
         beat = header_beat(header_step_ff, win_xs_ff, win_xe_ff, win_ys_ff, win_ye_ff);
      end else begin
         beat.is_data = 1'b1;
         case (mode_ff)
            MODE_RECT: begin
               beat.out_byte = second_byte_ff ? fill_color_ff[7:0] : fill_color_ff[15:8];
               beat.last     = second_byte_ff && (pixels_left_ff == 16'd1);
            end
            MODE_FRAME: begin
               beat.out_byte = second_byte_ff ? pix_data[15:8] : pix_data[7:0];
               beat.last     = frame_done;
            end
            default: begin
               beat.out_byte = 8'd0;
            end
         endcase
      end
   end

   assign status.busy      = (mode_ff != MODE_IDLE);
   assign status.need_read = (mode_ff == MODE_FRAME) && !in_header;
   assign status.rd_addr   = ADDR_W'(src_row_ff) * ADDR_W'(STORE_COLS) +
                             ADDR_W'(src_col_ff);

endmodule

// ----- src/lcd_window_fill_and_upscale_sender_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD window fill and upscale sender
// Serial TFT byte-stream generator with a 60x80 RGB565 frame store, store
// rectangle fill, direct panel rectangle fill and 2x2 upscaled frame send.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Transaction
//   req_bus   in         command: fill store, start rectangle, start frame, tick
//   rsp_bus   out        one panel byte with command/data flag and last mark
//
// A tick during a header or rectangle fill pushes its byte at once; a tick on a
// frame pixel byte first reads the store, and the byte is pushed from the read state.
// A store fill holds off new commands while it writes the clipped pixels.
// The store, queue bytes and fill data are not reset; control state resets synchronously.
// Up to two bytes wait in the output queue; a full queue also stalls commands.
//
module lcd_window_fill_and_upscale_sender_core import lcdwf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   lcdwf_req_if.sink   req_bus,
   lcdwf_rsp_if.source rsp_bus
);

   ctl_type        state_ff, state_in;
   beat_type       queue_ff [2];
   logic           wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   logic           accept, push, pop, rd_en, fill_busy;
   snd_ctrl_type   snd_ctrl;
   snd_status_type snd_status;
   beat_type       beat;
   store_wr_type   store_wr;
   logic [15:0]    rd_data;

   lcdwf_fill u_fill (
      .clock  (clock),
      .reset  (reset),
      .start  (accept && req_bus.cmd == CMD_FILL),
      .x      (req_bus.x),
      .y      (req_bus.y),
      .width  (req_bus.width),
      .height (req_bus.height),
      .color  (req_bus.color),
      .busy   (fill_busy),
      .wr     (store_wr)
   );

   // Writes happen only while a fill runs and reads only when a tick is accepted,
   // which needs an idle fill, so they cannot overlap and the store needs no forwarding.
   lcdwf_store u_store (
      .clock   (clock),
      .wr      (store_wr),
      .rd_en   (rd_en),
      .rd_addr (snd_status.rd_addr),
      .rd_data (rd_data)
   );

   lcdwf_sender u_sender (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (snd_ctrl),
      .x        (req_bus.x),
      .y        (req_bus.y),
      .width    (req_bus.width),
      .height   (req_bus.height),
      .color    (req_bus.color),
      .pix_data (rd_data),
      .status   (snd_status),
      .beat     (beat)
   );

   assign req_bus.ready = (state_ff == CTL_IDLE) && !fill_busy && (count_ff != 2'd2);
   assign accept        = req_bus.valid && req_bus.ready;
   assign pop           = rsp_bus.valid && rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= CTL_IDLE;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         state_ff  <= state_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= beat;
      end
   end

   always_comb begin
      state_in             = state_ff;
      push                 = 1'b0;
      rd_en                = 1'b0;
      snd_ctrl.start_rect  = accept && (req_bus.cmd == CMD_RECT);
      snd_ctrl.start_frame = accept && (req_bus.cmd == CMD_FRAME);
      snd_ctrl.advance     = 1'b0;
      case (state_ff)
         CTL_IDLE: begin
            if (accept && req_bus.cmd == CMD_TICK && snd_status.busy) begin
               if (snd_status.need_read) begin
                  rd_en    = 1'b1;
                  state_in = CTL_READ;
               end else begin
                  push             = 1'b1;
                  snd_ctrl.advance = 1'b1;
               end
            end
         end
         CTL_READ: begin
            push             = 1'b1;
            snd_ctrl.advance = 1'b1;
            state_in         = CTL_IDLE;
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase

      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   assign rsp_bus.valid    = (count_ff != 2'd0);
   assign rsp_bus.out_byte = queue_ff[rd_ptr_ff].out_byte;
   assign rsp_bus.is_data  = queue_ff[rd_ptr_ff].is_data;
   assign rsp_bus.last     = queue_ff[rd_ptr_ff].last;

   a_queue_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("output queue holds more than two bytes");

   a_read_one_cycle : assert property (@(posedge clock) disable iff (reset)
      state_ff == CTL_READ |=> state_ff == CTL_IDLE)
      else $error("store read state lasted more than one cycle");

   a_no_write_in_read : assert property (@(posedge clock) disable iff (reset)
      !(store_wr.en && state_ff == CTL_READ))
      else $error("store written while a pixel read is pending");

   a_push_has_room : assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != 2'd2) || pop)
      else $error("byte pushed into a full output queue");

endmodule
